// ----- rtl/core/rc4_pkg.sv -----
package rc4_pkg;

  // permutation geometry
  localparam int STATE_SIZE = 256;
  localparam int IDX_W      = $clog2(STATE_SIZE);

  // key and draw sizes
  localparam int KEY_BYTES  = 8;
  localparam int KEY_SEL_W  = $clog2(KEY_BYTES);
  localparam int DATA_W     = 64;
  localparam int COUNT_W    = 4;
  localparam logic [COUNT_W-1:0] MAX_DRAW = COUNT_W'(8);

  // action codes
  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  // write and read request to the permutation memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/rc4_req_if.sv -----
interface rc4_req_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [rc4_pkg::DATA_W-1:0]         seed_value;
  logic [rc4_pkg::COUNT_W-1:0]        byte_count;

  modport source (output valid, output action, output seed_value, output byte_count,
                  input ready);
  modport sink   (input valid, input action, input seed_value, input byte_count,
                  output ready);
endinterface

// ----- rtl/core/rc4_rsp_if.sv -----
interface rc4_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::DATA_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ----- rtl/core/rc4_keystream_generator.sv -----
// RC4 keystream generator. The 256-byte permutation sits in one synchronous
// single-read, single-write memory, and every read of it goes through that
// one read port, which sets the timing. A draw of n bytes (1 to 8, larger
// counts saturate to 8) runs through the states D_RJ, D_SW, D_RT and D_ACC
// for each byte: each byte reads S[i], reads S[j], writes S[i] and then S[j]
// for the swap, the second write while reading S[S[i]+S[j]], with forwarding
// of the swapped entries. A draw of zero bytes returns a zero word. A reseed
// runs a pass that loads the identity into all 256 entries, then the 256
// key-schedule steps, each through the states K_RK, K_RA, K_W1 and K_W2;
// it returns no word. Before the first reseed the permutation reads as
// zeros, so draws return zero. One item is worked at a time; a finished
// word waits in the output register while the next item is taken.
module rc4_keystream_generator (
  input  logic      clk,
  input  logic      rst,
  rc4_req_if.sink   req,
  rc4_rsp_if.source rsp
);

  rc4_pkg::mem_req_t         mem_req;
  logic [rc4_pkg::IDX_W-1:0] rdata;

  // sequencer for key schedule and output steps
  rc4_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // permutation store
  rc4_perm_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

endmodule

// ----- rtl/core/rc4_perm_ram.sv -----
module rc4_perm_ram (
  input  logic                            clk,
  input  rc4_pkg::mem_req_t               mem_req,
  output logic [rc4_pkg::IDX_W-1:0]       rdata
);

  logic [rc4_pkg::IDX_W-1:0] mem [rc4_pkg::STATE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[mem_req.raddr];
  end

endmodule

// ----- rtl/core/rc4_ctrl.sv -----
module rc4_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  rc4_req_if.sink                   req,
  rc4_rsp_if.source                 rsp,
  output rc4_pkg::mem_req_t         mem_req,
  input  logic [rc4_pkg::IDX_W-1:0] rdata
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_FILL  = 10'b00_0000_0010,
    ST_K_RK  = 10'b00_0000_0100,
    ST_K_RA  = 10'b00_0000_1000,
    ST_K_W1  = 10'b00_0001_0000,
    ST_K_W2  = 10'b00_0010_0000,
    ST_D_RJ  = 10'b00_0100_0000,
    ST_D_SW  = 10'b00_1000_0000,
    ST_D_RT  = 10'b01_0000_0000,
    ST_D_ACC = 10'b10_0000_0000
  } state_t;

  state_t                        state, state_next;
  logic                          seeded;
  logic                          post;
  logic [rc4_pkg::IDX_W-1:0]     idx_i, idx_j, k, a, b;
  logic                          use_a, use_b;
  logic [rc4_pkg::DATA_W-1:0]    seed;
  logic [rc4_pkg::DATA_W-1:0]    value;
  logic [rc4_pkg::COUNT_W-1:0]   cnt;
  logic                          out_valid;
  logic [rc4_pkg::DATA_W-1:0]    out_data;

  logic [rc4_pkg::IDX_W-1:0]     rd;
  logic [rc4_pkg::IDX_W-1:0]     kb;
  logic [rc4_pkg::IDX_W-1:0]     i_inc, j_draw, j_key, t_sum, c_byte;
  logic [rc4_pkg::COUNT_W-1:0]   cnt_sat;
  logic                          out_free;
  logic                          accept;

  // memory reads as zero until the first reseed
  assign rd      = seeded ? rdata : '0;
  assign kb      = seed[{k[rc4_pkg::KEY_SEL_W-1:0], 3'b000} +: rc4_pkg::IDX_W];
  assign i_inc   = rc4_pkg::IDX_W'(idx_i + 1'b1);
  assign j_draw  = rc4_pkg::IDX_W'(idx_j + rd);
  assign j_key   = rc4_pkg::IDX_W'(idx_j + rd + kb);
  assign t_sum   = rc4_pkg::IDX_W'(a + b);
  assign c_byte  = use_a ? a : (use_b ? b : rd);
  assign cnt_sat = (req.byte_count > rc4_pkg::MAX_DRAW) ? rc4_pkg::MAX_DRAW : req.byte_count;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && !post;
  assign accept    = req.valid && req.ready;

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_data;

  // memory access and next state
  always_comb begin
    state_next    = state;
    mem_req.we    = 1'b0;
    mem_req.waddr = k;
    mem_req.wdata = k;
    mem_req.raddr = i_inc;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == rc4_pkg::ACT_RESEED) begin
            state_next = ST_FILL;
          end else if (cnt_sat != '0) begin
            state_next = ST_D_RJ;
          end
        end
      end
      ST_FILL: begin
        mem_req.we = 1'b1;
        if (k == '1) begin
          state_next = ST_K_RK;
        end
      end
      ST_K_RK: begin
        mem_req.raddr = k;
        state_next    = ST_K_RA;
      end
      ST_K_RA: begin
        mem_req.raddr = j_key;
        state_next    = ST_K_W1;
      end
      ST_K_W1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k;
        mem_req.wdata = rd;
        state_next    = ST_K_W2;
      end
      ST_K_W2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_j;
        mem_req.wdata = a;
        state_next    = (k == '1) ? ST_IDLE : ST_K_RK;
      end
      ST_D_RJ: begin
        mem_req.raddr = j_draw;
        state_next    = ST_D_SW;
      end
      ST_D_SW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_i;
        mem_req.wdata = rd;
        state_next    = ST_D_RT;
      end
      ST_D_RT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_j;
        mem_req.wdata = a;
        mem_req.raddr = t_sum;
        state_next    = ST_D_ACC;
      end
      ST_D_ACC: begin
        state_next = (cnt == rc4_pkg::COUNT_W'(1)) ? ST_IDLE : ST_D_RJ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      post      <= 1'b0;
      out_valid <= 1'b0;
      idx_i     <= '0;
      idx_j     <= '0;
    end else begin
      state <= state_next;
      // finished word moves to the output register once it is free
      if (post && out_free) begin
        out_valid <= 1'b1;
        post      <= 1'b0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && req.action == rc4_pkg::ACT_RESEED) begin
            seeded <= 1'b1;
            idx_j  <= '0;
          end else if (accept && cnt_sat == '0) begin
            post <= 1'b1;
          end
        end
        ST_K_RA: begin
          idx_j <= j_key;
        end
        ST_K_W2: begin
          if (k == '1) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        ST_D_RJ: begin
          idx_i <= i_inc;
          idx_j <= j_draw;
        end
        ST_D_ACC: begin
          if (cnt == rc4_pkg::COUNT_W'(1)) begin
            post <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (post && out_free) begin
      out_data <= value;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          seed  <= req.seed_value;
          cnt   <= cnt_sat;
          value <= '0;
          k     <= '0;
        end
      end
      ST_FILL: begin
        k <= rc4_pkg::IDX_W'(k + 1'b1);
      end
      ST_K_RA: begin
        a <= rd;
      end
      ST_K_W2: begin
        k <= rc4_pkg::IDX_W'(k + 1'b1);
      end
      ST_D_RJ: begin
        a <= rd;
      end
      ST_D_SW: begin
        b <= rd;
      end
      ST_D_RT: begin
        // swapped entries are forwarded, the i slot only when j misses
        use_a <= (t_sum == idx_j);
        use_b <= (t_sum == idx_i);
      end
      ST_D_ACC: begin
        value <= {value[rc4_pkg::DATA_W-rc4_pkg::IDX_W-1:0], c_byte};
        cnt   <= rc4_pkg::COUNT_W'(cnt - 1'b1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/rc4_checker.sv -----
module rc4_checker (
  input  logic      clk,
  input  logic      rst,
  rc4_req_if.sink   req,
  rc4_rsp_if.source rsp
);

  logic       seeded;
  logic [1:0] pending;
  logic       req_acc, rsp_acc, draw_acc;

  assign req_acc  = req.valid && req.ready;
  assign rsp_acc  = rsp.valid && rsp.ready;
  assign draw_acc = req_acc && (req.action == rc4_pkg::ACT_DRAW);

  // draws whose word has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded  <= 1'b0;
      pending <= '0;
    end else begin
      if (req_acc && req.action == rc4_pkg::ACT_RESEED) begin
        seeded <= 1'b1;
      end
      pending <= 2'(pending + {1'b0, draw_acc} - {1'b0, rsp_acc});
    end
  end

  // a word waiting for the sink holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.random_value))
    else $error("result word changed while stalled");

  // no word without a draw behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> pending != 2'd0)
    else $error("result word without a pending draw");

  // every accepted item keeps the block busy in the cycle after the accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req.ready)
    else $error("input taken again right after an accept");

  // unseeded permutation yields zeros
  a_zero_unseeded: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !seeded |-> rsp.random_value == '0)
    else $error("nonzero word before first reseed");

  // reset clears the output
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result valid after reset");

endmodule

bind rc4_keystream_generator rc4_checker u_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
